// ===== rtl/kq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kq_pkg
// Shared types, constants and float helpers for the K-quant dot product block.
// ----------------------------------------------------------------------------
package kq_pkg;

    localparam int GROUPS = 16;
    localparam int CHUNKS = 16;
    localparam int PS_W = 17;
    localparam int AS_W = 13;

    localparam logic [0:0] ACTION_HEADER = 1'b0;
    localparam logic [0:0] ACTION_CHUNK  = 1'b1;
    localparam logic [0:0] ADDR_WEIGHT_FORMAT = 1'b0;

    // Fold float steps, issued in this order.
    localparam logic [2:0] FSEL_DSUMI  = 3'd0;
    localparam logic [2:0] FSEL_MSUMM  = 3'd1;
    localparam logic [2:0] FSEL_SUB    = 3'd2;
    localparam logic [2:0] FSEL_ASCALE = 3'd3;
    localparam logic [2:0] FSEL_ACC    = 3'd4;

    typedef struct packed {
        logic        action;
        logic [15:0] weight_scale;
        logic [15:0] min_scale;
        logic [31:0] act_scale;
        logic [63:0] scale_bytes_lo;
        logic [31:0] scale_bytes_hi;
        logic [63:0] nibble_bytes;
        logic [63:0] high_bit_bytes;
        logic [63:0] act_low;
        logic [63:0] act_high;
        logic        end_of_row;
    } in_item_t;

    typedef struct packed {
        logic [31:0] dot_value;
        logic [15:0] blocks_summed;
    } out_item_t;

    // Floating-point sequencer opcodes.
    typedef enum logic [2:0] {
        FOP_MUL,
        FOP_SUB,
        FOP_ADD
    } fop_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_header;
        logic lane_chunk;
        logic clear_block;
        logic fold_start;
        logic [3:0] fold_idx;
        logic fold_acc_int;
        logic fp_start;
        logic [2:0] fp_sel;
        logic emit;
        logic clear_row;
        logic count_block;
    } kq_cmd_t;

    typedef struct packed {
        logic [3:0] chunk_index;
        logic       fp_done;
    } kq_status_t;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [31:0] r;
        logic [4:0]  lz;
        logic [9:0]  m;
        ex = h[14:10];
        man = h[9:0];
        r = '0;
        lz = '0;
        m = '0;
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                r = {h[15], 31'd0};
            end else begin
                for (int k = 9; k >= 0; k--) begin
                    if (man[k] && lz == 5'd0) begin
                        lz = 5'(10 - k);
                    end
                end
                m = 10'(man << lz);
                r = {h[15], 8'(8'd113 - 8'(lz)), m, 13'd0};
            end
        end else if (ex == 5'd31) begin
            r = {h[15], 8'hFF, man, 13'd0};
        end else begin
            r = {h[15], 8'(8'(ex) + 8'd112), man, 13'd0};
        end
        return r;
    endfunction

    // Int to float conversion with round to nearest even, 32-bit signed input.
    function automatic logic [31:0] int_to_single(input logic signed [31:0] v);
        logic        s;
        logic [31:0] a;
        logic [5:0]  msb;
        logic [31:0] n;
        logic [23:0] mant;
        logic        g;
        logic        st;
        logic [24:0] rm;
        logic [7:0]  e;
        s = v[31];
        a = s ? 32'(-v) : 32'(v);
        msb = '0;
        for (int k = 0; k < 32; k++) begin
            if (a[k]) begin
                msb = 6'(k);
            end
        end
        n = a << (6'd31 - msb);
        mant = n[31:8];
        g = n[7];
        st = |n[6:0];
        rm = {1'b0, mant} + 25'(g && (st || mant[0]));
        e = 8'(8'd127 + 8'(msb));
        if (rm[24]) begin
            e = e + 8'd1;
            rm = rm >> 1;
        end
        if (a == 32'd0) begin
            return 32'd0;
        end
        return {s, e, rm[22:0]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kq_fpu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kq_fpu
// Single-precision multiply, add and subtract with round to nearest even.
// ----------------------------------------------------------------------------
module kq_fpu (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire kq_pkg::fop_t op,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             done,
    output logic [31:0]      result
);
    import kq_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_S1,
        F_S2
    } fstate_t;

    fstate_t     state_reg;
    fop_t        op_reg;
    logic [31:0] a_reg;
    logic [31:0] b_reg;
    logic [47:0] prod_reg;
    logic [31:0] result_reg;
    logic        done_reg;

    logic [31:0] res_next;

    function automatic logic is_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 23'd0;
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    // Round and pack: sign, biased exponent relative to bit 50 of sig, 51-bit sig.
    function automatic logic [31:0] pack(input logic s, input logic signed [11:0] exp_in,
                                         input logic [50:0] sig);
        logic [5:0]  msb;
        logic [50:0] n;
        logic signed [11:0] e;
        logic [50:0] sh;
        logic [23:0] mant;
        logic        g;
        logic        st;
        logic [24:0] rm;
        logic [5:0]  rs;
        msb = '0;
        for (int k = 0; k < 51; k++) begin
            if (sig[k]) begin
                msb = 6'(k);
            end
        end
        if (sig == 51'd0) begin
            return {s, 31'd0};
        end
        n = sig << (6'd50 - msb);
        e = exp_in - 12'(50) + 12'(msb);
        if (e < 12'sd1) begin
            rs = (e < -12'sd30) ? 6'd31 : 6'(12'sd1 - e);
            sh = n >> rs;
            st = |(n & ((51'd1 << rs) - 51'd1));
            e = 12'sd0;
        end else begin
            sh = n;
            st = 1'b0;
        end
        mant = sh[50:27];
        g = sh[26];
        st = st | (|sh[25:0]);
        rm = {1'b0, mant} + 25'(g && (st || mant[0]));
        if (rm[24]) begin
            rm = rm >> 1;
            e = e + 12'sd1;
        end else if (e == 12'sd0 && rm[23]) begin
            e = 12'sd1;
        end
        if (e >= 12'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, e[7:0], rm[22:0]};
    endfunction

    function automatic logic [31:0] addsub(input logic [31:0] x, input logic [31:0] y);
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [26:0] mx;
        logic [26:0] my;
        logic [7:0]  d;
        logic [26:0] sy;
        logic        sticky;
        logic [27:0] sum;
        logic        rs;
        logic [31:0] big;
        logic [31:0] sml;
        if (is_nan(x) || is_nan(y)) begin
            return 32'h7FC00000;
        end
        if (is_inf(x) && is_inf(y)) begin
            return (x[31] == y[31]) ? x : 32'h7FC00000;
        end
        if (is_inf(x)) begin
            return x;
        end
        if (is_inf(y)) begin
            return y;
        end
        if (is_zero(x) && is_zero(y)) begin
            return {x[31] & y[31], 31'd0};
        end
        if (x[30:0] >= y[30:0]) begin
            big = x;
            sml = y;
        end else begin
            big = y;
            sml = x;
        end
        ex = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        ey = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mx = {big[30:23] != 8'd0, big[22:0], 3'd0};
        my = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
        d = ex - ey;
        if (d > 8'd26) begin
            sy = 27'd0;
            sticky = my != 27'd0;
        end else begin
            sy = my >> d;
            sticky = (my & ((27'd1 << d) - 27'd1)) != 27'd0;
        end
        sy[0] = sy[0] | sticky;
        if (big[31] == sml[31]) begin
            sum = {1'b0, mx} + {1'b0, sy};
        end else begin
            sum = {1'b0, mx} - {1'b0, sy};
        end
        if (sum == 28'd0) begin
            return 32'd0;
        end
        rs = big[31];
        // value = sum * 2^(ex-127-26); bit 50 reference => exp_in = ex + 24
        return pack(rs, 12'(ex) + 12'sd24, {23'd0, sum});
    endfunction

    always_comb begin
        logic [7:0] ea;
        logic [7:0] eb;
        logic signed [11:0] ep;
        res_next = result_reg;
        ep = '0;
        ea = (a_reg[30:23] == 8'd0) ? 8'd1 : a_reg[30:23];
        eb = (b_reg[30:23] == 8'd0) ? 8'd1 : b_reg[30:23];
        case (op_reg)
            FOP_MUL: begin
                if (is_nan(a_reg) || is_nan(b_reg)) begin
                    res_next = 32'h7FC00000;
                end else if ((is_inf(a_reg) && is_zero(b_reg)) ||
                             (is_zero(a_reg) && is_inf(b_reg))) begin
                    res_next = 32'h7FC00000;
                end else if (is_inf(a_reg) || is_inf(b_reg)) begin
                    res_next = {a_reg[31] ^ b_reg[31], 8'hFF, 23'd0};
                end else begin
                    // prod = ma*mb * 2^(ea+eb-254-46); msb-ref bit 50 -> exp_in
                    ep = 12'(ea) + 12'(eb) - 12'sd127 + 12'sd4 - 12'sd0;
                    res_next = pack(a_reg[31] ^ b_reg[31], ep - 12'sd0,
                                    {3'd0, prod_reg});
                end
            end
            FOP_SUB: res_next = addsub(a_reg, {~b_reg[31], b_reg[30:0]});
            FOP_ADD: res_next = addsub(a_reg, b_reg);
            default: res_next = result_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                F_IDLE: begin
                    if (start) begin
                        op_reg <= op;
                        a_reg <= a;
                        b_reg <= b;
                        state_reg <= F_S1;
                    end
                end
                F_S1: begin
                    prod_reg <= {(a_reg[30:23] != 8'd0), a_reg[22:0]} *
                                {(b_reg[30:23] != 8'd0), b_reg[22:0]};
                    state_reg <= F_S2;
                end
                F_S2: begin
                    result_reg <= res_next;
                    done_reg <= 1'b1;
                    state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

// ===== rtl/kq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kq_datapath
// Integer lanes, per-16 sums, scale decode, fold integer sums and float unit.
// ----------------------------------------------------------------------------
module kq_datapath (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire kq_pkg::kq_cmd_t cmd,
    output kq_pkg::kq_status_t status,
    input  wire kq_pkg::in_item_t item,
    input  wire logic        weight_format,
    output kq_pkg::out_item_t result
);
    import kq_pkg::*;

    logic signed [PS_W-1:0] ps_reg [GROUPS];
    logic signed [AS_W-1:0] as_reg [GROUPS];
    logic [3:0]   chunk_reg;
    logic [63:0]  hdr_reg;
    logic [95:0]  sb_reg;
    logic [31:0]  acc_reg;
    logic [15:0]  cnt_reg;
    logic signed [31:0] sumi_reg;
    logic signed [31:0] summ_reg;
    logic [31:0]  p_reg;
    logic [31:0]  t_reg;
    logic [31:0]  r_reg;
    out_item_t    out_reg;

    logic [1:0]   c_sel;
    logic [4:0]   l_off;
    logic signed [PS_W-1:0] ps_add [GROUPS];
    logic signed [AS_W-1:0] as_add [GROUPS];
    logic [5:0]   sc;
    logic [5:0]   mn;
    logic [7:0]   sbyte [12];
    fop_t         fop;
    logic [31:0]  fa;
    logic [31:0]  fb;
    logic         fdone;
    logic [31:0]  fres;

    assign c_sel = chunk_reg[3:2];
    assign l_off = {chunk_reg[1:0], 3'd0};

    always_comb begin
        logic [4:0] wl;
        logic [4:0] wh;
        logic signed [7:0] al;
        logic signed [7:0] ah;
        logic [3:0] gl;
        logic [3:0] gh;
        for (int g = 0; g < GROUPS; g++) begin
            ps_add[g] = '0;
            as_add[g] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            wl = {1'b0, item.nibble_bytes[8*i +: 4]};
            wh = {1'b0, item.nibble_bytes[8*i+4 +: 4]};
            if (weight_format) begin
                wl[4] = item.high_bit_bytes[8*i + 2*c_sel];
                wh[4] = item.high_bit_bytes[8*i + 2*c_sel + 1];
            end
            al = item.act_low[8*i +: 8];
            ah = item.act_high[8*i +: 8];
            gl = {c_sel, 1'b0, l_off[4]};
            gh = {c_sel, 1'b1, l_off[4]};
            ps_add[gl] = ps_add[gl] + PS_W'($signed({1'b0, wl}) * al);
            as_add[gl] = as_add[gl] + AS_W'(al);
            ps_add[gh] = ps_add[gh] + PS_W'($signed({1'b0, wh}) * ah);
            as_add[gh] = as_add[gh] + AS_W'(ah);
        end
    end

    always_comb begin
        logic [3:0] j;
        for (int k = 0; k < 12; k++) begin
            sbyte[k] = sb_reg[8*k +: 8];
        end
        j = {1'b0, cmd.fold_idx[2:0]};
        if (j < 4'd4) begin
            sc = sbyte[j[1:0]][5:0];
            mn = sbyte[j[1:0] + 2'd0 + 4][5:0];
        end else begin
            sc = {sbyte[j[1:0]][7:6], sbyte[8 + j[1:0]][3:0]};
            mn = {sbyte[4 + j[1:0]][7:6], sbyte[8 + j[1:0]][7:4]};
        end
    end

    always_comb begin
        fop = FOP_MUL;
        fa = '0;
        fb = '0;
        case (cmd.fp_sel)
            FSEL_DSUMI: begin
                fa = half_to_single(hdr_reg[15:0]);
                fb = int_to_single(sumi_reg);
            end
            FSEL_MSUMM: begin
                fa = half_to_single(hdr_reg[31:16]);
                fb = int_to_single(summ_reg);
            end
            FSEL_SUB: begin
                fop = FOP_SUB;
                fa = p_reg;
                fb = fres;
            end
            FSEL_ASCALE: begin
                fa = hdr_reg[63:32];
                fb = t_reg;
            end
            FSEL_ACC: begin
                fop = FOP_ADD;
                fa = acc_reg;
                fb = r_reg;
            end
            default: begin
                fop = FOP_MUL;
            end
        endcase
    end

    kq_fpu u_fpu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.fp_start),
        .op     (fop),
        .a      (fa),
        .b      (fb),
        .done   (fdone),
        .result (fres)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < GROUPS; g++) begin
                ps_reg[g] <= '0;
                as_reg[g] <= '0;
            end
            chunk_reg <= '0;
            hdr_reg <= '0;
            sb_reg <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
            sumi_reg <= '0;
            summ_reg <= '0;
        end else begin
            if (cmd.load_header) begin
                hdr_reg <= {item.act_scale, item.min_scale, item.weight_scale};
                sb_reg <= {item.scale_bytes_hi, item.scale_bytes_lo};
            end
            if (cmd.lane_chunk) begin
                for (int g = 0; g < GROUPS; g++) begin
                    ps_reg[g] <= ps_reg[g] + ps_add[g];
                    as_reg[g] <= as_reg[g] + as_add[g];
                end
                chunk_reg <= chunk_reg + 4'd1;
            end
            if (cmd.fold_start) begin
                sumi_reg <= '0;
                summ_reg <= '0;
            end
            if (cmd.fold_acc_int) begin
                sumi_reg <= sumi_reg + 32'($signed({1'b0, sc}) *
                            (32'(ps_reg[2*cmd.fold_idx[2:0]]) +
                             32'(ps_reg[2*cmd.fold_idx[2:0]+1])));
                summ_reg <= summ_reg + 32'($signed({1'b0, mn}) *
                            (32'(as_reg[2*cmd.fold_idx[2:0]]) +
                             32'(as_reg[2*cmd.fold_idx[2:0]+1])));
            end
            if (fdone) begin
                case (cmd.fp_sel)
                    FSEL_DSUMI: p_reg <= fres;
                    FSEL_SUB: t_reg <= fres;
                    FSEL_ASCALE: r_reg <= fres;
                    FSEL_ACC: acc_reg <= fres;
                    default: ;
                endcase
            end
            if (cmd.count_block && cnt_reg != 16'hFFFF) begin
                cnt_reg <= cnt_reg + 16'd1;
            end
            if (cmd.clear_block) begin
                for (int g = 0; g < GROUPS; g++) begin
                    ps_reg[g] <= '0;
                    as_reg[g] <= '0;
                end
                chunk_reg <= '0;
            end
            if (cmd.emit) begin
                out_reg.dot_value <= (acc_reg[30:23] == 8'hFF && acc_reg[22:0] != 23'd0) ?
                                     32'h7FC00000 : acc_reg;
                out_reg.blocks_summed <= cnt_reg;
            end
            if (cmd.clear_row) begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end
        end
    end

    assign status.chunk_index = chunk_reg;
    assign status.fp_done = fdone;
    assign result = out_reg;
endmodule
`default_nettype wire

// ===== rtl/kq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kq_ctrl
// Sequencer for chunk intake, block fold and result hand-off.
// ----------------------------------------------------------------------------
module kq_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_action,
    input  wire logic          in_eor,
    output logic               out_valid,
    input  wire logic          out_ready,
    output kq_pkg::kq_cmd_t    cmd,
    input  wire kq_pkg::kq_status_t status
);
    import kq_pkg::*;

    typedef enum logic [2:0] {
        S_RUN,
        S_INT,
        S_FP_ISSUE,
        S_FP_WAIT,
        S_EMIT,
        S_HOLD
    } state_t;

    state_t     state_reg;
    logic [3:0] idx_reg;
    logic [2:0] fp_reg;
    logic       eor_reg;
    logic       ov_reg;
    logic       take;

    assign in_ready = (state_reg == S_RUN) && !ov_reg;
    assign take = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb begin
        cmd = '0;
        cmd.fold_idx = idx_reg;
        cmd.fp_sel = fp_reg;
        case (state_reg)
            S_RUN: begin
                if (take) begin
                    if (in_action == ACTION_HEADER) begin
                        cmd.load_header = 1'b1;
                        cmd.clear_block = 1'b1;
                    end else begin
                        cmd.lane_chunk = 1'b1;
                        cmd.fold_start = 1'b1;
                    end
                end
            end
            S_INT: cmd.fold_acc_int = 1'b1;
            S_FP_ISSUE: cmd.fp_start = 1'b1;
            S_EMIT: begin
                cmd.emit = eor_reg;
                cmd.clear_row = eor_reg;
                cmd.clear_block = 1'b1;
            end
            default: ;
        endcase
        if (state_reg == S_FP_WAIT && status.fp_done && fp_reg == FSEL_ACC) begin
            cmd.count_block = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN;
            idx_reg <= '0;
            fp_reg <= FSEL_DSUMI;
            eor_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (ov_reg && out_ready) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_RUN: begin
                    if (take && in_action == ACTION_CHUNK) begin
                        eor_reg <= in_eor;
                        idx_reg <= '0;
                        if (status.chunk_index == 4'(CHUNKS - 1)) begin
                            state_reg <= S_INT;
                        end else if (in_eor) begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_INT: begin
                    idx_reg <= idx_reg + 4'd1;
                    if (idx_reg == 4'd7) begin
                        fp_reg <= FSEL_DSUMI;
                        state_reg <= S_FP_ISSUE;
                    end
                end
                S_FP_ISSUE: state_reg <= S_FP_WAIT;
                S_FP_WAIT: begin
                    if (status.fp_done) begin
                        if (fp_reg == FSEL_ACC) begin
                            state_reg <= S_EMIT;
                        end else begin
                            fp_reg <= fp_reg + 3'd1;
                            state_reg <= S_FP_ISSUE;
                        end
                    end
                end
                S_EMIT: begin
                    if (eor_reg) begin
                        ov_reg <= 1'b1;
                    end
                    state_reg <= S_RUN;
                end
                default: state_reg <= S_RUN;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/kquant_q4k_q5k_dot_q8k.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kquant_q4k_q5k_dot_q8k
// K-quantized 4/5-bit weight by 8-bit activation row dot product.
// ----------------------------------------------------------------------------
// A header or a chunk item is taken while the sequencer is in its run state and no
// result waits. The sixteenth chunk of a block starts a fold in which no request is
// accepted: the scale multiply-accumulate, five float operations in turn on one shared
// float unit, and a closing step for the block. An end of row before the sixteenth
// chunk goes straight to that closing step. A row result is held in an output register until
// taken; no new request is accepted while a result waits.
module kquant_q4k_q5k_dot_q8k (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire kq_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output kq_pkg::out_item_t      m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [1:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import kq_pkg::*;

    logic       fmt_reg;
    kq_cmd_t    cmd;
    kq_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            fmt_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'd0, fmt_reg} : 32'd0;

    kq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_action(s_data.action),
        .in_eor   (s_data.end_of_row),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    kq_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .item         (s_data),
        .weight_format(fmt_reg),
        .result       (m_data)
    );
endmodule
`default_nettype wire

// ===== rtl/kq_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kq_checker
// Port-level checks for the K-quant dot product block.
// ----------------------------------------------------------------------------
module kq_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic pready
);
    a_no_take_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken while result pending");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_ready_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid |-> !$isunknown(s_ready)) else $error("request ready unknown");
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready) else $error("pready low");
endmodule

bind kquant_q4k_q5k_dot_q8k kq_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .pready(pready)
);
`default_nettype wire

// ===== tb/tb_kquant_q4k_q5k_dot_q8k.sv =====
// ----------------------------------------------------------------------------
// tb_kquant_q4k_q5k_dot_q8k
// Checks the K-quant 4/5-bit by 8-bit row dot product against a bit-accurate
// in-bench model of its integer lanes and float fold, under random idling on
// both channels and with the weight format switched between phases.
// ----------------------------------------------------------------------------
module tb_kquant_q4k_q5k_dot_q8k;
    import kq_pkg::*;

    localparam int LIMIT = 600000;
    localparam int DRAIN = 60;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    kquant_q4k_q5k_dot_q8k i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    in_item_t pending_requests[$];
    out_item_t expected_sums[$];
    int errors = 0;
    int cycle = 0;
    logic calm = 1'b0;

    // Model state.
    logic [31:0] row_acc = '0;
    int prod_sum[16];
    int act_sum[16];
    int chunk_pos = 0;
    logic [15:0] held_d = '0;
    logic [15:0] held_dmin = '0;
    logic [31:0] held_a = '0;
    logic [7:0] held_sb[12];
    int folded_blocks = 0;
    logic fmt_5bit = 1'b0;

    function automatic real single_to_real(input logic [31:0] b);
        logic [63:0] d;
        d = '0;
        if (b[30:23] == 8'd255) begin
            d = {b[31], 11'h7FF, b[22:0], 29'd0};
        end else if (b[30:23] == 8'd0) begin
            return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** -149);
        end else begin
            d = {b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    // Rounds a double to single precision, nearest even.
    function automatic logic [31:0] real_to_single(input real x);
        logic [63:0] d;
        logic [63:0] mant;
        logic [63:0] kept;
        logic [63:0] rest;
        logic [63:0] half;
        logic [63:0] bits;
        int e;
        int sh;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 0) ? 32'h7FC00000 : {d[63], 31'h7F800000};
        end
        if (d[62:52] == 11'd0) begin
            return {d[63], 31'd0};
        end
        e = int'(d[62:52]) - 1023;
        mant = {11'd0, 1'b1, d[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 63) begin
            sh = 63;
        end
        kept = mant >> sh;
        rest = mant & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rest > half || (rest == half && kept[0])) begin
            kept = kept + 64'd1;
        end
        if (e >= -126) begin
            bits = (64'(e + 127) << 23) + kept - (64'd1 << 23);
        end else begin
            bits = kept;
        end
        if (bits >= 64'h7F800000) begin
            bits = 64'h7F800000;
        end
        return {d[63], bits[30:0]};
    endfunction

    function automatic logic [31:0] half_bits_to_single(input logic [15:0] h);
        if (h[14:10] == 5'd0) begin
            return real_to_single((h[15] ? -1.0 : 1.0) * real'(h[9:0]) * (2.0 ** -24));
        end
        if (h[14:10] == 5'd31) begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        return {h[15], 8'(h[14:10] + 112), h[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        return real_to_single(single_to_real(a) * single_to_real(b));
    endfunction

    function automatic void clear_partial_block();
        for (int g = 0; g < 16; g++) begin
            prod_sum[g] = 0;
            act_sum[g] = 0;
        end
        chunk_pos = 0;
    endfunction

    function automatic void fold_into_row();
        int sumi;
        int summ;
        int sc;
        int mn;
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] t;
        logic [31:0] r;
        sumi = 0;
        summ = 0;
        for (int j = 0; j < 8; j++) begin
            if (j < 4) begin
                sc = held_sb[j] & 63;
                mn = held_sb[j + 4] & 63;
            end else begin
                sc = (held_sb[j + 4] & 8'h0F) | ((held_sb[j - 4] >> 6) << 4);
                mn = (held_sb[j + 4] >> 4) | ((held_sb[j] >> 6) << 4);
            end
            sumi += sc * (prod_sum[2 * j] + prod_sum[2 * j + 1]);
            summ += mn * (act_sum[2 * j] + act_sum[2 * j + 1]);
        end
        p = fmul(half_bits_to_single(held_d), real_to_single(real'(sumi)));
        q = fmul(half_bits_to_single(held_dmin), real_to_single(real'(summ)));
        t = real_to_single(single_to_real(p) - single_to_real(q));
        r = fmul(held_a, t);
        row_acc = real_to_single(single_to_real(row_acc) + single_to_real(r));
        if (folded_blocks < 65535) begin
            folded_blocks++;
        end
    endfunction

    // Advances the row model by one accepted request.
    function automatic void dot_row_step(input in_item_t it);
        int c;
        int l;
        int wl;
        int wh;
        int al;
        int ah;
        int pl;
        int ph;
        logic [7:0] qb;
        logic [7:0] hb;
        out_item_t res;
        if (it.action == ACTION_HEADER) begin
            held_d = it.weight_scale;
            held_dmin = it.min_scale;
            held_a = it.act_scale;
            for (int i = 0; i < 8; i++) held_sb[i] = it.scale_bytes_lo[8 * i +: 8];
            for (int i = 0; i < 4; i++) held_sb[8 + i] = it.scale_bytes_hi[8 * i +: 8];
            clear_partial_block();
            return;
        end
        c = ((chunk_pos * 8) / 32) & 3;
        l = (chunk_pos * 8) % 32;
        for (int i = 0; i < 8; i++) begin
            qb = it.nibble_bytes[8 * i +: 8];
            hb = it.high_bit_bytes[8 * i +: 8];
            wl = qb[3:0];
            wh = qb[7:4];
            al = $signed(it.act_low[8 * i +: 8]);
            ah = $signed(it.act_high[8 * i +: 8]);
            if (fmt_5bit) begin
                wl += 16 * hb[2 * c];
                wh += 16 * hb[2 * c + 1];
            end
            pl = (c * 64 + l + i) % 256;
            ph = (c * 64 + 32 + l + i) % 256;
            prod_sum[pl >> 4] += wl * al;
            act_sum[pl >> 4] += al;
            prod_sum[ph >> 4] += wh * ah;
            act_sum[ph >> 4] += ah;
        end
        chunk_pos++;
        if (chunk_pos >= CHUNKS) begin
            fold_into_row();
            clear_partial_block();
        end
        if (!it.end_of_row) begin
            return;
        end
        res.dot_value = row_acc;
        if (row_acc[30:23] == 8'hFF && row_acc[22:0] != 0) begin
            res.dot_value = 32'h7FC00000;
        end
        res.blocks_summed = 16'(folded_blocks);
        expected_sums.push_back(res);
        row_acc = '0;
        folded_blocks = 0;
        clear_partial_block();
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [15:0] rand_half();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
    endfunction

    function automatic logic [31:0] rand_single();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return {1'($urandom), 8'($urandom_range(110, 135)), 23'($urandom)};
    endfunction

    function automatic in_item_t header_req(input logic [15:0] d, input logic [15:0] dmin,
                                            input logic [31:0] a);
        in_item_t it;
        it = '0;
        it.action = ACTION_HEADER;
        it.weight_scale = d;
        it.min_scale = dmin;
        it.act_scale = a;
        it.scale_bytes_lo = {$urandom, $urandom};
        it.scale_bytes_hi = $urandom;
        it.nibble_bytes = {$urandom, $urandom};
        it.act_low = {$urandom, $urandom};
        return it;
    endfunction

    function automatic in_item_t chunk_req(input logic eor);
        in_item_t it;
        it = '0;
        it.action = ACTION_CHUNK;
        it.nibble_bytes = {$urandom, $urandom};
        it.high_bit_bytes = {$urandom, $urandom};
        it.act_low = {$urandom, $urandom};
        it.act_high = {$urandom, $urandom};
        it.weight_scale = 16'($urandom);
        it.act_scale = $urandom;
        it.end_of_row = eor;
        return it;
    endfunction

    // Driver.
    always @(posedge aclk) begin
        int gap;
        logic busy;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap = 0;
        end else begin
            busy = s_valid;
            if (s_valid && s_ready) begin
                dot_row_step(s_data);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap > 0) begin
                    gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    s_data <= pending_requests.pop_front();
                    s_valid <= 1'b1;
                    gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycle);
        errors++;
    endtask

    // Monitor.
    always @(posedge aclk) begin
        out_item_t want;
        cycle <= cycle + 1;
        if ($urandom_range(0, 199) == 0) calm <= ~calm;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch("unexpected row result", m_data.dot_value, '0);
                end else begin
                    want = expected_sums.pop_front();
                    if (m_data.dot_value !== want.dot_value)
                        report_mismatch("dot_value", m_data.dot_value, want.dot_value);
                    if (m_data.blocks_summed !== want.blocks_summed)
                        report_mismatch("blocks_summed", 32'(m_data.blocks_summed),
                                        32'(want.blocks_summed));
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) < 65)
                       || ($urandom_range(0, 9) == 0 && m_ready);
        end
    end

    always @(posedge aclk) begin
        if (cycle > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_weight_format(input logic v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'(4 * ADDR_WEIGHT_FORMAT);
        pwdata <= {31'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        fmt_5bit = v;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() > 0 || s_valid || expected_sums.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic queue_random_phase(input int count);
        int n;
        int blocks;
        int stop;
        n = 0;
        while (n < count) begin
            blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
            for (int b = 0; b < blocks; b++) begin
                pending_requests.push_back(header_req(rand_half(), rand_half(), rand_single()));
                stop = 16;
                if ($urandom_range(0, 11) == 0) stop = $urandom_range(1, 15);
                for (int k = 0; k < stop; k++) begin
                    pending_requests.push_back(chunk_req(
                        (b == blocks - 1 || stop < 16) && k == stop - 1));
                end
                n += stop + 1;
                if (stop < 16) break;
                if ($urandom_range(0, 19) == 0) begin
                    pending_requests.push_back(chunk_req(1'b1));
                    n++;
                    break;
                end
            end
        end
    endtask

    initial begin
        in_item_t it;
        for (int i = 0; i < 12; i++) held_sb[i] = '0;
        clear_partial_block();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Chunks before any header, and an end of row on a header.
        pending_requests.push_back(chunk_req(1'b0));
        pending_requests.push_back(chunk_req(1'b1));
        it = header_req(16'h3C00, 16'h3800, 32'h3F800000);
        it.end_of_row = 1'b1;
        pending_requests.push_back(it);
        // Full block at the value extremes.
        it = header_req(16'h7BFF, 16'h0001, 32'h7F7FFFFF);
        it.scale_bytes_lo = '1;
        it.scale_bytes_hi = '1;
        pending_requests.push_back(it);
        for (int k = 0; k < 16; k++) begin
            it = chunk_req(k == 15);
            it.nibble_bytes = '1;
            it.high_bit_bytes = '1;
            it.act_low = {8{8'h80}};
            it.act_high = {8{8'h7F}};
            pending_requests.push_back(it);
        end
        // Header mid-block, then an early end of row.
        pending_requests.push_back(header_req(16'h7C00, 16'h7E00, 32'h00000001));
        pending_requests.push_back(chunk_req(1'b0));
        pending_requests.push_back(header_req(16'h03FF, 16'h8000, 32'hFF800000));
        pending_requests.push_back(chunk_req(1'b1));
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_weight_format(ph[0] ^ 1'b1);
            queue_random_phase(245);
            wait_idle();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kq_pkg.sv
rtl/kq_fpu.sv
rtl/kq_datapath.sv
rtl/kq_ctrl.sv
rtl/kquant_q4k_q5k_dot_q8k.sv
rtl/kq_checker.sv
tb/tb_kquant_q4k_q5k_dot_q8k.sv
